>>> rtl/spg_pkg.sv
// spg_pkg: shared types and constants of the seeded permutation generator
// no dependencies; imported by spg_mix and seeded_permutation_generator
package spg_pkg;

	localparam logic [1:0] OP_GEN = 2'd0;
	localparam logic [1:0] OP_FWD = 2'd1;
	localparam logic [1:0] OP_INV = 2'd2;

	localparam logic [1:0] ST_GEN   = 2'd0;
	localparam logic [1:0] ST_OK    = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_NOGEN = 2'd3;

	localparam logic REG_SEED  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	// compare width covering the largest supported count
	localparam int CMP_W = 17;

	typedef enum logic [2:0] {
		MX_IDLE,
		MX_ADD,
		MX_XOR,
		MX_MUL,
		MX_FIN
	} mix_state_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_FILL,
		SQ_RNG,
		SQ_RNGW,
		SQ_MODW,
		SQ_RDA,
		SQ_RDB,
		SQ_WRA,
		SQ_WRB,
		SQ_INVR,
		SQ_INVW,
		SQ_RDOP,
		SQ_RDCAP,
		SQ_OUT
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic start;
	} mix_req_t;

endpackage

>>> rtl/spg_mix.sv
// spg_mix: splitmix64 generator built around one shared 32x32 multiplier
// depends on spg_pkg
module spg_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  spg_pkg::mix_req_t req,
	input  logic [31:0]       seed,
	output logic              done,
	output logic [63:0]       rnd
);
	import spg_pkg::*;

	mix_state_t  state_q, state_d;
	logic [63:0] st_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [1:0]  ph_q;
	logic        second_q;
	logic [63:0] cst;
	logic [31:0] mul_a, mul_b;

	always_comb begin
		state_d = state_q;
		case (state_q)
			MX_IDLE: if (req.start) state_d = MX_ADD;
			MX_ADD:  state_d = MX_XOR;
			MX_XOR:  state_d = MX_MUL;
			MX_MUL:  if (ph_q == 2'd3) state_d = second_q ? MX_FIN : MX_XOR;
			MX_FIN:  state_d = MX_IDLE;
			default: state_d = MX_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == MX_FIN);
	end

	assign rnd = acc_q ^ (acc_q >> SHIFT_C);
	assign cst = second_q ? MIX_MUL_B : MIX_MUL_A;

	// low 64 bits of the product from three partial products
	always_comb begin
		case (ph_q)
			2'd1: begin
				mul_a = z_q[31:0];
				mul_b = cst[63:32];
			end
			2'd2: begin
				mul_a = z_q[63:32];
				mul_b = cst[31:0];
			end
			default: begin
				mul_a = z_q[31:0];
				mul_b = cst[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MX_IDLE;
			st_q     <= '0;
			ph_q     <= '0;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.load) st_q <= 64'(seed);
			case (state_q)
				MX_ADD: begin
					st_q     <= st_q + GOLDEN_INC;
					second_q <= 1'b0;
				end
				MX_XOR: ph_q <= '0;
				MX_MUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) second_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MX_XOR: z_q <= second_q ? (acc_q ^ (acc_q >> SHIFT_B)) : (st_q ^ (st_q >> SHIFT_A));
			MX_MUL: begin
				if (ph_q != 2'd3) prod_q <= 64'(mul_a) * 64'(mul_b);
				if (ph_q == 2'd1) acc_q <= prod_q;
				else if (ph_q != 2'd0) acc_q <= acc_q + {prod_q[31:0], 32'h0};
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/spg_mod.sv
// spg_mod: bit-serial restoring remainder of a 64-bit value by a narrow divisor
// depends on nothing beyond its parameter
module spg_mod #(
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [63:0]   dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   sh;
	logic [DW:0]   nxt;

	assign sh   = {rem_q, dvd_q[63]};
	assign nxt  = (sh >= {1'b0, div_q}) ? (sh - {1'b0, div_q}) : sh;
	assign done = done_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= DW'(nxt);
		end
	end

endmodule

>>> rtl/seeded_permutation_generator.sv
// Seeded permutation generator. A generate item fills the forward table with the
// identity, then shuffles it from the top down: each of the n-1 steps runs
// splitmix64 on one shared 32x32 multiplier, a bit-serial 64-step modulo and a
// swap through the registered forward table (two reads, two writes), and a last
// pass over the table builds the inverse table. A read passes through the
// registered table port before its result is offered. The block takes no item
// until the result of the current one has been delivered.
// depends on spg_pkg, spg_mix, spg_mod
module seeded_permutation_generator #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // op[1:0], position[11:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // entry_value[9:0], status[11:10], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import spg_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	seq_state_t  state_q, state_d;
	logic [31:0] seed_q;
	logic [10:0] count_q;
	logic        table_valid_q;
	logic [CW-1:0] gen_count_q;

	logic [CW-1:0] n_q, i_q;
	logic [AW-1:0] idx_q, j_q, a_q;
	logic [9:0]    pos_q;
	logic [1:0]    op_q;
	logic [9:0]    value_q;
	logic [1:0]    status_q;

	logic [AW-1:0] fwd_mem [MAX_ENTRIES];
	logic [AW-1:0] inv_mem [MAX_ENTRIES];
	logic [AW-1:0] fwd_rd_q, inv_rd_q;
	logic [AW-1:0] fwd_raddr, fwd_waddr, fwd_wdata;
	logic          fwd_we;

	logic [1:0]    in_op;
	logic [9:0]    in_pos;
	logic          s_acc;
	logic [CW-1:0] n_sat;
	logic          is_read, in_range, last_idx;

	mix_req_t      mix_req;
	logic          mix_done;
	logic [63:0]   mix_rnd;
	logic          mod_start, mod_done;
	logic [CW-1:0] mod_rem;

	assign in_op    = s_tdata[1:0];
	assign in_pos   = s_tdata[11:2];
	assign s_acc    = s_tvalid && s_tready;
	assign n_sat    = (CMP_W'(count_q) > CMP_W'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_q);
	assign is_read  = (in_op == OP_FWD) || (in_op == OP_INV);
	assign in_range = CMP_W'(in_pos) < CMP_W'(gen_count_q);
	assign last_idx = (CW'(idx_q) == n_q - CW'(1));
	assign cfg_ready = 1'b1;
	assign m_tdata  = {4'h0, status_q, value_q};

	spg_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mix_req),
		.seed   (seed_q),
		.done   (mix_done),
		.rnd    (mix_rnd)
	);

	spg_mod #(.DW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mix_rnd),
		.divisor  (i_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (s_acc) begin
					if (in_op == OP_GEN) state_d = (n_sat == '0) ? SQ_OUT : SQ_FILL;
					else if (is_read && table_valid_q && in_range) state_d = SQ_RDOP;
					else state_d = SQ_OUT;
				end
			end
			SQ_FILL:  if (last_idx) state_d = (n_q == CW'(1)) ? SQ_INVR : SQ_RNG;
			SQ_RNG:   state_d = SQ_RNGW;
			SQ_RNGW:  if (mix_done) state_d = SQ_MODW;
			SQ_MODW:  if (mod_done) state_d = SQ_RDA;
			SQ_RDA:   state_d = SQ_RDB;
			SQ_RDB:   state_d = SQ_WRA;
			SQ_WRA:   state_d = SQ_WRB;
			SQ_WRB:   state_d = (i_q == CW'(2)) ? SQ_INVR : SQ_RNG;
			SQ_INVR:  state_d = SQ_INVW;
			SQ_INVW:  state_d = last_idx ? SQ_OUT : SQ_INVR;
			SQ_RDOP:  state_d = SQ_RDCAP;
			SQ_RDCAP: state_d = SQ_OUT;
			SQ_OUT:   if (m_tready) state_d = SQ_IDLE;
			default:  state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == SQ_IDLE);
		m_tvalid      = (state_q == SQ_OUT);
		mix_req.load  = s_acc && (in_op == OP_GEN);
		mix_req.start = (state_q == SQ_RNG);
		mod_start     = (state_q == SQ_RNGW) && mix_done;
		fwd_we        = 1'b0;
		fwd_waddr     = idx_q;
		fwd_wdata     = idx_q;
		fwd_raddr     = AW'(pos_q);
		case (state_q)
			SQ_FILL: fwd_we = 1'b1;
			SQ_WRA: begin
				fwd_we    = 1'b1;
				fwd_waddr = AW'(i_q - CW'(1));
				fwd_wdata = fwd_rd_q;
			end
			SQ_WRB: begin
				fwd_we    = 1'b1;
				fwd_waddr = j_q;
				fwd_wdata = a_q;
			end
			SQ_RDA:  fwd_raddr = AW'(i_q - CW'(1));
			SQ_RDB:  fwd_raddr = j_q;
			SQ_INVR: fwd_raddr = idx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fwd_we) fwd_mem[fwd_waddr] <= fwd_wdata;
		fwd_rd_q <= fwd_mem[fwd_raddr];
		if (state_q == SQ_INVW) inv_mem[fwd_rd_q] <= idx_q;
		inv_rd_q <= inv_mem[AW'(pos_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= SQ_IDLE;
			seed_q        <= '0;
			count_q       <= '0;
			table_valid_q <= 1'b0;
			gen_count_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEED:  seed_q  <= cfg_data;
					REG_COUNT: count_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (s_acc && (in_op == OP_GEN) && (n_sat == '0)) begin
				table_valid_q <= 1'b1;
				gen_count_q   <= '0;
			end
			if ((state_q == SQ_INVW) && last_idx) begin
				table_valid_q <= 1'b1;
				gen_count_q   <= n_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (s_acc) begin
					pos_q   <= in_pos;
					op_q    <= in_op;
					n_q     <= n_sat;
					i_q     <= n_sat;
					idx_q   <= '0;
					value_q <= '0;
					if (in_op == OP_GEN) status_q <= ST_GEN;
					else if (!is_read) status_q <= ST_RANGE;
					else if (!table_valid_q) status_q <= ST_NOGEN;
					else if (!in_range) status_q <= ST_RANGE;
					else status_q <= ST_OK;
				end
			end
			SQ_FILL: idx_q <= last_idx ? '0 : idx_q + AW'(1);
			SQ_MODW: if (mod_done) j_q <= AW'(mod_rem);
			SQ_RDB:  a_q <= fwd_rd_q;
			SQ_WRB:  i_q <= i_q - CW'(1);
			SQ_INVW: begin
				idx_q <= idx_q + AW'(1);
				if (last_idx) begin
					value_q  <= '0;
					status_q <= ST_GEN;
				end
			end
			SQ_RDCAP: begin
				value_q  <= 10'((op_q == OP_FWD) ? fwd_rd_q : inv_rd_q);
				status_q <= ST_OK;
			end
			default: ;
		endcase
	end

endmodule
